[rtl/lidar_cluster_target_selector_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the lidar cluster target selector
// Concurrent checks, compiled out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef LIDAR_CLUSTER_TARGET_SELECTOR_DEFINES_SVH
`define LIDAR_CLUSTER_TARGET_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define LCTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lcts check failed");
`define LCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lcts check failed");
`else
`define LCTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/lcts_pkg.sv]
// ----------------------------------------------------------------------------
// lcts_pkg
// Shared widths, register indexes, outcome codes and types.
// ----------------------------------------------------------------------------
package lcts_pkg;

	localparam int PT_W           = 15;   // point coordinate width
	localparam int CFG_W          = 14;
	localparam int MINP_W         = 11;
	localparam int LOST_W         = 4;
	localparam int CCNT_W         = 11;
	localparam int OUTC_W         = 2;
	localparam int MAX_POINTS_DEF = 1024;
	localparam int QDEPTH         = 4;
	localparam int ADDR_W         = 5;
	localparam int DATA_W         = 32;
	localparam int REG_IDX_W      = 3;

	localparam logic [REG_IDX_W-1:0] REG_MIN_POINTS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_MIN   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SIZE_MAX   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DIM_MIN    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DIM_MAX    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TRACK_GATE = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MAX_LOST   = 3'd6;

	localparam logic [OUTC_W-1:0] OUT_FRESH  = 2'd0;
	localparam logic [OUTC_W-1:0] OUT_HELD   = 2'd1;
	localparam logic [OUTC_W-1:0] OUT_ORIGIN = 2'd2;
	localparam logic [OUTC_W-1:0] OUT_NEVER  = 2'd3;

	typedef struct packed {
		logic [MINP_W-1:0] min_points;
		logic [CFG_W-1:0]  size_min;
		logic [CFG_W-1:0]  size_max;
		logic [CFG_W-1:0]  dim_min;
		logic [CFG_W-1:0]  dim_max;
		logic [CFG_W-1:0]  track_gate;
		logic [LOST_W-1:0] max_lost;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[rtl/lcts_fifo.sv]
// ----------------------------------------------------------------------------
// lcts_fifo
// Short record queue between cluster front end and selection back end.
// ----------------------------------------------------------------------------
module lcts_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 pop,
	output logic [WIDTH-1:0]     rdata,
	output lcts_pkg::q_stat_t    stat
);
	import lcts_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push, do_pop;

	assign stat.full  = (cnt_q == (PTR_W+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/lcts_front.sv]
// ----------------------------------------------------------------------------
// lcts_front
// Takes points, keeps the open cluster's box, sums and count, and queues
// one record per closed cluster or scan end.
// ----------------------------------------------------------------------------
module lcts_front #(
	parameter int MAX_POINTS = lcts_pkg::MAX_POINTS_DEF,
	parameter int CNT_W      = $clog2(MAX_POINTS + 1),
	parameter int SUM_W      = lcts_pkg::PT_W + $clog2(MAX_POINTS) + 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             has_point,
	input  logic signed [lcts_pkg::PT_W-1:0] point_x,
	input  logic signed [lcts_pkg::PT_W-1:0] point_y,
	input  logic                             cluster_end,
	input  logic                             scan_end,
	input  lcts_pkg::q_stat_t                q_stat,
	output logic                             push,
	output logic        [lcts_pkg::PT_W-1:0] rec_w,
	output logic        [lcts_pkg::PT_W-1:0] rec_l,
	output logic signed [SUM_W-1:0]          rec_sx,
	output logic signed [SUM_W-1:0]          rec_sy,
	output logic        [CNT_W-1:0]          rec_cnt,
	output logic                             rec_scan
);
	import lcts_pkg::*;

	logic signed [PT_W-1:0]  minx_q, maxx_q, miny_q, maxy_q;
	logic signed [PT_W-1:0]  nx_minx, nx_maxx, nx_miny, nx_maxy;
	logic signed [SUM_W-1:0] sx_q, sy_q, nx_sx, nx_sy;
	logic [CNT_W-1:0]        cnt_q, nx_cnt;
	logic signed [PT_W:0]    dw, dl;
	logic                    acc, first, take, close;

	assign in_stall = q_stat.full;
	assign acc      = in_valid && !in_stall;
	assign first    = (cnt_q == '0);
	assign take     = has_point && (cnt_q < CNT_W'(MAX_POINTS));

	// first point of a cluster seeds the box and sums directly
	always_comb begin
		nx_minx = minx_q;
		nx_maxx = maxx_q;
		nx_miny = miny_q;
		nx_maxy = maxy_q;
		nx_sx   = sx_q;
		nx_sy   = sy_q;
		nx_cnt  = cnt_q;
		if (take) begin
			nx_minx = (first || point_x < minx_q) ? point_x : minx_q;
			nx_maxx = (first || point_x > maxx_q) ? point_x : maxx_q;
			nx_miny = (first || point_y < miny_q) ? point_y : miny_q;
			nx_maxy = (first || point_y > maxy_q) ? point_y : maxy_q;
			nx_sx   = first ? SUM_W'(point_x) : sx_q + SUM_W'(point_x);
			nx_sy   = first ? SUM_W'(point_y) : sy_q + SUM_W'(point_y);
			nx_cnt  = cnt_q + 1'b1;
		end
	end

	assign close    = (cluster_end || scan_end) && (nx_cnt != '0);
	assign dw       = {nx_maxy[PT_W-1], nx_maxy} - {nx_miny[PT_W-1], nx_miny};
	assign dl       = {nx_maxx[PT_W-1], nx_maxx} - {nx_minx[PT_W-1], nx_minx};
	assign push     = acc && (close || scan_end);
	assign rec_w    = dw[PT_W-1:0];
	assign rec_l    = dl[PT_W-1:0];
	assign rec_sx   = nx_sx;
	assign rec_sy   = nx_sy;
	assign rec_cnt  = close ? nx_cnt : '0;
	assign rec_scan = scan_end;

	always_ff @(posedge clk) begin
		if (acc && take) begin
			minx_q <= nx_minx;
			maxx_q <= nx_maxx;
			miny_q <= nx_miny;
			maxy_q <= nx_maxy;
			sx_q   <= nx_sx;
			sy_q   <= nx_sy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			cnt_q <= close ? '0 : nx_cnt;
		end
	end

endmodule

[rtl/lcts_back.sv]
// ----------------------------------------------------------------------------
// lcts_back
// Shape tests, centroid divide, nearest-candidate pick and hold/lost
// tracking; one result per scan end.
// ----------------------------------------------------------------------------
module lcts_back #(
	parameter int MAX_POINTS = lcts_pkg::MAX_POINTS_DEF,
	parameter int CNT_W      = $clog2(MAX_POINTS + 1),
	parameter int SUM_W      = lcts_pkg::PT_W + $clog2(MAX_POINTS) + 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lcts_pkg::cfg_t                     cfg,
	input  lcts_pkg::q_stat_t                  q_stat,
	output logic                               pop,
	input  logic        [lcts_pkg::PT_W-1:0]   rec_w,
	input  logic        [lcts_pkg::PT_W-1:0]   rec_l,
	input  logic signed [SUM_W-1:0]            rec_sx,
	input  logic signed [SUM_W-1:0]            rec_sy,
	input  logic        [CNT_W-1:0]            rec_cnt,
	input  logic                               rec_scan,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [lcts_pkg::PT_W-1:0]   target_x,
	output logic signed [lcts_pkg::PT_W-1:0]   target_y,
	output logic        [lcts_pkg::OUTC_W-1:0] outcome,
	output logic        [lcts_pkg::CCNT_W-1:0] candidate_count
);
	import lcts_pkg::*;

	localparam int IT_W  = $clog2(SUM_W);
	localparam int SQ_W  = 2 * PT_W;
	localparam int DG_W  = SQ_W + 1;
	localparam int CSQ_W = 2 * CFG_W;
	localparam int DSQ_W = 2 * (PT_W + 1);
	localparam int D_W   = DSQ_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_TEST, ST_DIV, ST_FIX, ST_DIST, ST_DSQ, ST_CMP, ST_RES
	} state_t;

	state_t state_q;

	logic [PT_W-1:0]         w_q, l_q;
	logic                    sxneg_q, syneg_q, scan_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SUM_W-1:0]        dvx_q, dvy_q;
	logic [CNT_W:0]          remx_q, remy_q;
	logic [IT_W-1:0]         it_q;
	logic [SQ_W-1:0]         wsq_q, lsq_q;
	logic [CSQ_W-1:0]        sminsq_q, smaxsq_q, gsq_q;
	logic                    pts_ok_q, dim_ok_q;
	logic signed [PT_W:0]    cx_q, cy_q;
	logic [PT_W:0]           adx_q, ady_q;
	logic [DSQ_W-1:0]        dxsq_q, dysq_q;
	logic signed [PT_W-1:0]  best_x_q, best_y_q, prev_x_q, prev_y_q;
	logic [D_W-1:0]          best_d_q;
	logic [CCNT_W-1:0]       cand_q;
	logic                    pv_q;
	logic [LOST_W-1:0]       lost_q;

	logic [SUM_W-1:0]        absx, absy;
	logic [DG_W-1:0]         diag;
	logic                    cand_ok;
	logic [CNT_W:0]          remx_n, remy_n;
	logic                    gex, gey;
	logic signed [PT_W-1:0]  rx, ry;
	logic signed [PT_W+1:0]  dx, dy;
	logic [D_W-1:0]          cand_d;
	logic                    wok, lok, can_hold, out_free, res_load;
	logic [OUTC_W-1:0]       res_oc;
	logic signed [PT_W-1:0]  res_x, res_y;

	assign pop  = (state_q == ST_IDLE) && !q_stat.empty;
	assign absx = rec_sx[SUM_W-1] ? SUM_W'(-rec_sx) : SUM_W'(rec_sx);
	assign absy = rec_sy[SUM_W-1] ? SUM_W'(-rec_sy) : SUM_W'(rec_sy);
	assign wok  = (w_q > PT_W'(cfg.dim_min)) && (w_q < PT_W'(cfg.dim_max));
	assign lok  = (l_q > PT_W'(cfg.dim_min)) && (l_q < PT_W'(cfg.dim_max));
	assign diag = DG_W'(wsq_q) + DG_W'(lsq_q);
	assign cand_ok = pts_ok_q && dim_ok_q && (diag >= DG_W'(sminsq_q))
			&& (diag <= DG_W'(smaxsq_q));

	// restoring divide, one quotient bit a cycle, x and y side by side
	assign remx_n = {remx_q[CNT_W-1:0], dvx_q[SUM_W-1]};
	assign remy_n = {remy_q[CNT_W-1:0], dvy_q[SUM_W-1]};
	assign gex    = (remx_n >= {1'b0, cnt_q});
	assign gey    = (remy_n >= {1'b0, cnt_q});

	assign rx     = pv_q ? prev_x_q : '0;
	assign ry     = pv_q ? prev_y_q : '0;
	assign dx     = {cx_q[PT_W], cx_q} - (PT_W+2)'(rx);
	assign dy     = {cy_q[PT_W], cy_q} - (PT_W+2)'(ry);
	assign cand_d = D_W'(dxsq_q) + D_W'(dysq_q);

	assign can_hold = pv_q && (lost_q < cfg.max_lost);
	assign out_free = !out_valid || !out_stall;
	assign res_load = (state_q == ST_RES) && out_free;

	always_comb begin
		res_oc = OUT_FRESH;
		res_x  = best_x_q;
		res_y  = best_y_q;
		if (cand_q == '0) begin
			if (can_hold) begin
				res_oc = OUT_HELD;
				res_x  = prev_x_q;
				res_y  = prev_y_q;
			end else begin
				res_oc = pv_q ? OUT_ORIGIN : OUT_NEVER;
				res_x  = '0;
				res_y  = '0;
			end
		end else if (can_hold && (best_d_q > D_W'(gsq_q))) begin
			res_oc = OUT_HELD;
			res_x  = prev_x_q;
			res_y  = prev_y_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					w_q     <= rec_w;
					l_q     <= rec_l;
					cnt_q   <= rec_cnt;
					sxneg_q <= rec_sx[SUM_W-1];
					syneg_q <= rec_sy[SUM_W-1];
					dvx_q   <= absx + SUM_W'(rec_cnt >> 1);
					dvy_q   <= absy + SUM_W'(rec_cnt >> 1);
					scan_q  <= rec_scan;
					gsq_q   <= cfg.track_gate * cfg.track_gate;
				end
			end
			ST_SQ: begin
				wsq_q    <= w_q * w_q;
				lsq_q    <= l_q * l_q;
				sminsq_q <= cfg.size_min * cfg.size_min;
				smaxsq_q <= cfg.size_max * cfg.size_max;
				pts_ok_q <= ({{MINP_W{1'b0}}, cnt_q} >= {{CNT_W{1'b0}}, cfg.min_points});
				dim_ok_q <= wok || lok;
			end
			ST_TEST: begin
				remx_q <= '0;
				remy_q <= '0;
				it_q   <= IT_W'(SUM_W - 1);
			end
			ST_DIV: begin
				remx_q <= gex ? remx_n - {1'b0, cnt_q} : remx_n;
				remy_q <= gey ? remy_n - {1'b0, cnt_q} : remy_n;
				dvx_q  <= {dvx_q[SUM_W-2:0], gex};
				dvy_q  <= {dvy_q[SUM_W-2:0], gey};
				it_q   <= it_q - 1'b1;
			end
			ST_FIX: begin
				cx_q <= sxneg_q ? -$signed({1'b0, dvx_q[PT_W-1:0]})
						: $signed({1'b0, dvx_q[PT_W-1:0]});
				cy_q <= syneg_q ? -$signed({1'b0, dvy_q[PT_W-1:0]})
						: $signed({1'b0, dvy_q[PT_W-1:0]});
			end
			ST_DIST: begin
				adx_q <= dx[PT_W+1] ? (PT_W+1)'(-dx) : (PT_W+1)'(dx);
				ady_q <= dy[PT_W+1] ? (PT_W+1)'(-dy) : (PT_W+1)'(dy);
			end
			ST_DSQ: begin
				dxsq_q <= adx_q * adx_q;
				dysq_q <= ady_q * ady_q;
			end
			ST_CMP: begin
				if (cand_q == '0 || cand_d < best_d_q) begin
					best_d_q <= cand_d;
					best_x_q <= cx_q[PT_W-1:0];
					best_y_q <= cy_q[PT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// control, tracking state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cand_q          <= '0;
			pv_q            <= 1'b0;
			lost_q          <= '0;
			prev_x_q        <= '0;
			prev_y_q        <= '0;
			out_valid       <= 1'b0;
			target_x        <= '0;
			target_y        <= '0;
			outcome         <= OUT_NEVER;
			candidate_count <= '0;
		end else begin
			if (out_valid && !out_stall && !res_load) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (rec_cnt != '0) begin
							state_q <= ST_SQ;
						end else begin
							state_q <= ST_RES;
						end
					end
				end
				ST_SQ:   state_q <= ST_TEST;
				ST_TEST: begin
					if (cand_ok) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= scan_q ? ST_RES : ST_IDLE;
					end
				end
				ST_DIV: begin
					if (it_q == '0) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX:  state_q <= ST_DIST;
				ST_DIST: state_q <= ST_DSQ;
				ST_DSQ:  state_q <= ST_CMP;
				ST_CMP: begin
					if (cand_q != {CCNT_W{1'b1}}) begin
						cand_q <= cand_q + 1'b1;
					end
					state_q <= scan_q ? ST_RES : ST_IDLE;
				end
				ST_RES: begin
					if (res_load) begin
						out_valid       <= 1'b1;
						target_x        <= res_x;
						target_y        <= res_y;
						outcome         <= res_oc;
						candidate_count <= cand_q;
						if (res_oc == OUT_HELD) begin
							lost_q <= lost_q + 1'b1;
						end else if (res_oc == OUT_FRESH) begin
							lost_q <= '0;
						end
						// origin with no track yet leaves prev untouched
						if (!(res_x == '0 && res_y == '0 && !pv_q)) begin
							prev_x_q <= res_x;
							prev_y_q <= res_y;
							pv_q     <= 1'b1;
						end
						cand_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/lidar_cluster_target_selector.sv]
// ----------------------------------------------------------------------------
// lidar_cluster_target_selector
// Clusters lidar points into candidates and picks one tracked target a scan.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  input     in   in_valid / in_stall   has_point point_x point_y cluster_end scan_end
//  result    out  out_valid / out_stall target_x target_y outcome candidate_count
//  config    in   APB write/read        min_points .. max_lost, 4-byte stride
//
//  Front end takes one item per cycle while the 4-entry queue has room.
//  Each candidate cluster takes the back end through squaring, the shape test,
//  the one-bit-a-cycle centroid divider, fix, distance, square and compare; a
//  rejected one stops after the test. A scan end adds the result state, which a
//  bare scan end enters from idle. Back end waits in its result state while out_stall
//  holds the output register. Reset loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`include "lidar_cluster_target_selector_defines.svh"

module lidar_cluster_target_selector #(
	parameter int MAX_POINTS = lcts_pkg::MAX_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               has_point,
	input  logic signed [lcts_pkg::PT_W-1:0]   point_x,
	input  logic signed [lcts_pkg::PT_W-1:0]   point_y,
	input  logic                               cluster_end,
	input  logic                               scan_end,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [lcts_pkg::PT_W-1:0]   target_x,
	output logic signed [lcts_pkg::PT_W-1:0]   target_y,
	output logic        [lcts_pkg::OUTC_W-1:0] outcome,
	output logic        [lcts_pkg::CCNT_W-1:0] candidate_count,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic        [lcts_pkg::ADDR_W-1:0] paddr,
	input  logic        [lcts_pkg::DATA_W-1:0] pwdata,
	output logic        [lcts_pkg::DATA_W-1:0] prdata,
	output logic                               pready
);
	import lcts_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SUM_W = PT_W + $clog2(MAX_POINTS) + 1;
	localparam int REC_W = 2 * PT_W + 2 * SUM_W + CNT_W + 1;

	cfg_t                    cfg_q;
	q_stat_t                 q_stat;
	logic [REG_IDX_W-1:0]    reg_idx;
	logic                    wr_en;
	logic                    push, pop;
	logic [PT_W-1:0]         f_w, f_l, b_w, b_l;
	logic signed [SUM_W-1:0] f_sx, f_sy, b_sx, b_sy;
	logic [CNT_W-1:0]        f_cnt, b_cnt;
	logic                    f_scan, b_scan;
	logic [REC_W-1:0]        q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_points <= MINP_W'(5);
			cfg_q.size_min   <= CFG_W'(82);
			cfg_q.size_max   <= CFG_W'(614);
			cfg_q.dim_min    <= CFG_W'(82);
			cfg_q.dim_max    <= CFG_W'(358);
			cfg_q.track_gate <= CFG_W'(512);
			cfg_q.max_lost   <= LOST_W'(6);
		end else if (wr_en) begin
			case (reg_idx)
				REG_MIN_POINTS: cfg_q.min_points <= pwdata[MINP_W-1:0];
				REG_SIZE_MIN:   cfg_q.size_min   <= pwdata[CFG_W-1:0];
				REG_SIZE_MAX:   cfg_q.size_max   <= pwdata[CFG_W-1:0];
				REG_DIM_MIN:    cfg_q.dim_min    <= pwdata[CFG_W-1:0];
				REG_DIM_MAX:    cfg_q.dim_max    <= pwdata[CFG_W-1:0];
				REG_TRACK_GATE: cfg_q.track_gate <= pwdata[CFG_W-1:0];
				REG_MAX_LOST:   cfg_q.max_lost   <= pwdata[LOST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_POINTS: prdata = DATA_W'(cfg_q.min_points);
			REG_SIZE_MIN:   prdata = DATA_W'(cfg_q.size_min);
			REG_SIZE_MAX:   prdata = DATA_W'(cfg_q.size_max);
			REG_DIM_MIN:    prdata = DATA_W'(cfg_q.dim_min);
			REG_DIM_MAX:    prdata = DATA_W'(cfg_q.dim_max);
			REG_TRACK_GATE: prdata = DATA_W'(cfg_q.track_gate);
			REG_MAX_LOST:   prdata = DATA_W'(cfg_q.max_lost);
			default:        prdata = '0;
		endcase
	end

	lcts_front #(
		.MAX_POINTS (MAX_POINTS),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.has_point   (has_point),
		.point_x     (point_x),
		.point_y     (point_y),
		.cluster_end (cluster_end),
		.scan_end    (scan_end),
		.q_stat      (q_stat),
		.push        (push),
		.rec_w       (f_w),
		.rec_l       (f_l),
		.rec_sx      (f_sx),
		.rec_sy      (f_sy),
		.rec_cnt     (f_cnt),
		.rec_scan    (f_scan)
	);

	assign q_wdata = {f_w, f_l, f_sx, f_sy, f_cnt, f_scan};
	assign {b_w, b_l, b_sx, b_sy, b_cnt, b_scan} = q_rdata;

	lcts_fifo #(
		.WIDTH (REC_W),
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	lcts_back #(
		.MAX_POINTS (MAX_POINTS),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_stat          (q_stat),
		.pop             (pop),
		.rec_w           (b_w),
		.rec_l           (b_l),
		.rec_sx          (b_sx),
		.rec_sy          (b_sy),
		.rec_cnt         (b_cnt),
		.rec_scan        (b_scan),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.target_x        (target_x),
		.target_y        (target_y),
		.outcome         (outcome),
		.candidate_count (candidate_count)
	);

	`LCTS_ASSERT_IMP(a_q_full_not_empty, clk, arst_n, q_stat.full, !q_stat.empty)
	`LCTS_ASSERT_IMP(a_push_has_room, clk, arst_n, push, !q_stat.full)
	`LCTS_ASSERT_IMP(a_origin_zero, clk, arst_n, out_valid && (outcome == OUT_ORIGIN || outcome == OUT_NEVER), target_x == '0 && target_y == '0)
	`LCTS_ASSERT_NEXT(a_pop_leaves_idle, clk, arst_n, pop, !pop)

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar cluster target selector: drives point
// streams with random bursts and gaps, predicts the scan results with its
// own model of the selector and compares each result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
	import lcts_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic has_point = 1'b0;
	logic signed [PT_W-1:0] point_x = '0;
	logic signed [PT_W-1:0] point_y = '0;
	logic cluster_end = 1'b0;
	logic scan_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [PT_W-1:0] target_x;
	logic signed [PT_W-1:0] target_y;
	logic [OUTC_W-1:0] outcome;
	logic [CCNT_W-1:0] candidate_count;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	lidar_cluster_target_selector DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic signed [PT_W-1:0] tx;
		logic signed [PT_W-1:0] ty;
		logic [OUTC_W-1:0] oc;
		logic [CCNT_W-1:0] cc;
	} scan_result_t;

	scan_result_t expected_scans[$];
	int errors = 0;
	int cycles = 0;
	bit hold_off = 1'b0;
	int stall_pct = 30;
	int gap_pct = 30;

	// predictor state
	cfg_t cfg;
	longint bminx, bmaxx, bminy, bmaxy, sumx, sumy, prevx, prevy, bestx, besty;
	longint unsigned bestd;
	int npts, ncand, lost;
	bit prevv;

	function automatic void clear_cluster();
		bminx = 32767; bminy = 32767; bmaxx = -32768; bmaxy = -32768;
		sumx = 0; sumy = 0; npts = 0;
	endfunction

	function automatic longint rdiv(longint s, int n);
		longint m, q;
		m = s < 0 ? -s : s;
		q = (m + n / 2) / n;
		return s < 0 ? -q : q;
	endfunction

	function automatic void close_cluster();
		longint unsigned w, l, dg, d, smin, smax;
		longint cx, cy, dx, dy;
		bit ok;
		w = bmaxy - bminy;
		l = bmaxx - bminx;
		dg = w * w + l * l;
		smin = cfg.size_min; smax = cfg.size_max;
		ok = npts != 0 && npts >= cfg.min_points && dg >= smin * smin && dg <= smax * smax
			&& ((w > cfg.dim_min && w < cfg.dim_max) || (l > cfg.dim_min && l < cfg.dim_max));
		if (ok) begin
			cx = rdiv(sumx, npts);
			cy = rdiv(sumy, npts);
			dx = prevv ? cx - prevx : cx;
			dy = prevv ? cy - prevy : cy;
			d = dx * dx + dy * dy;
			if (ncand == 0 || d < bestd) begin
				bestd = d; bestx = cx; besty = cy;
			end
			if (ncand < 2047) ncand++;
		end
		clear_cluster();
	endfunction

	function automatic void predict_item(bit hp, longint px, longint py, bit ce, bit se);
		scan_result_t r;
		longint unsigned g;
		longint tx, ty;
		if (hp && npts < MAX_POINTS_DEF) begin
			if (px < bminx) bminx = px;
			if (px > bmaxx) bmaxx = px;
			if (py < bminy) bminy = py;
			if (py > bmaxy) bmaxy = py;
			sumx += px; sumy += py; npts++;
		end
		if ((ce || se) && npts > 0) close_cluster();
		if (!se) return;
		tx = 0; ty = 0;
		g = cfg.track_gate;
		if (ncand == 0) begin
			if (prevv && lost < cfg.max_lost) begin
				lost++; tx = prevx; ty = prevy; r.oc = OUT_HELD;
			end else
				r.oc = prevv ? OUT_ORIGIN : OUT_NEVER;
		end else if (prevv && bestd > g * g && lost < cfg.max_lost) begin
			lost++; tx = prevx; ty = prevy; r.oc = OUT_HELD;
		end else begin
			lost = 0; tx = bestx; ty = besty; r.oc = OUT_FRESH;
		end
		if (!(tx == 0 && ty == 0 && !prevv)) begin
			prevx = tx; prevy = ty; prevv = 1'b1;
		end
		r.tx = PT_W'(tx); r.ty = PT_W'(ty); r.cc = CCNT_W'(ncand);
		expected_scans = {expected_scans, r};
		bestx = 0; besty = 0; bestd = 32'h7FFFFFFF; ncand = 0;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		scan_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_scans.size() == 0)
				report_mismatch("unexpected result", outcome, -1);
			else begin
				e = expected_scans.pop_front();
				if (target_x !== e.tx) report_mismatch("target_x", target_x, e.tx);
				if (target_y !== e.ty) report_mismatch("target_y", target_y, e.ty);
				if (outcome !== e.oc) report_mismatch("outcome", outcome, e.oc);
				if (candidate_count !== e.cc)
					report_mismatch("candidate_count", candidate_count, e.cc);
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		out_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("lidar_cluster_target_selector verification failed");
			$finish;
		end
	end

	task automatic cfg_write(logic [REG_IDX_W-1:0] idx, int unsigned v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_MIN_POINTS: cfg.min_points = MINP_W'(v);
			REG_SIZE_MIN:   cfg.size_min = CFG_W'(v);
			REG_SIZE_MAX:   cfg.size_max = CFG_W'(v);
			REG_DIM_MIN:    cfg.dim_min = CFG_W'(v);
			REG_DIM_MAX:    cfg.dim_max = CFG_W'(v);
			REG_TRACK_GATE: cfg.track_gate = CFG_W'(v);
			default:        cfg.max_lost = LOST_W'(v);
		endcase
	endtask

	int burst_left = 0;

	// one item transfer, with bursty gaps
	task automatic send_item(bit hp, int px, int py, bit ce, bit se);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(99) < gap_pct) repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		burst_left--;
		@(posedge clk);
		in_valid <= 1'b1; has_point <= hp; point_x <= PT_W'(px); point_y <= PT_W'(py);
		cluster_end <= ce; scan_end <= se;
		do @(posedge clk); while (in_stall);
		predict_item(hp, px, py, ce, se);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_scans.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// cluster of n points spread around (cx, cy)
	task automatic send_cluster(int cx, int cy, int n, int spread, bit se);
		int px, py;
		for (int i = 0; i < n; i++) begin
			px = cx + $signed($urandom_range(0, 2 * spread)) - spread;
			py = cy + $signed($urandom_range(0, 2 * spread)) - spread;
			if (px > 16383) px = 16383;
			if (px < -16384) px = -16384;
			if (py > 16383) py = 16383;
			if (py < -16384) py = -16384;
			send_item(1'b1, px, py, i == n - 1, se && i == n - 1);
		end
	endtask

	task automatic test_directed();
		send_item(1'b0, 0, 0, 1'b0, 1'b1);              // never acquired
		send_item(1'b0, 0, 0, 1'b1, 1'b0);              // empty cluster end
		send_cluster(1000, -1000, 6, 120, 1'b1);        // fresh
		send_cluster(8000, 8000, 6, 120, 1'b1);         // beyond the gate
		send_item(1'b0, 0, 0, 1'b0, 1'b1);              // no candidate
		send_item(1'b1, 16383, -16384, 1'b0, 1'b0);
		send_item(1'b1, -16384, 16383, 1'b0, 1'b0);
		send_item(1'b1, 0, 0, 1'b0, 1'b1);              // scan end closes cluster
		send_cluster(0, 0, 5, 100, 1'b0);
		send_cluster(0, 0, 5, 100, 1'b1);               // tie
		drain();
	endtask

	task automatic test_lost_limit();
		cfg_write(REG_MAX_LOST, 0);
		send_item(1'b0, 0, 0, 1'b0, 1'b1);
		send_cluster(10000, 10000, 6, 120, 1'b1);
		drain();
		cfg_write(REG_MAX_LOST, 15);
		for (int i = 0; i < 17; i++) send_item(1'b0, 0, 0, 1'b0, 1'b1);
		drain();
	endtask

	task automatic test_big_cluster();
		cfg_write(REG_MIN_POINTS, 1024);
		cfg_write(REG_SIZE_MAX, 16383);
		cfg_write(REG_DIM_MAX, 16383);
		send_cluster(-3000, 2000, 1030, 200, 1'b1);
		drain();
		cfg_write(REG_MIN_POINTS, 0);
		cfg_write(REG_SIZE_MIN, 0);
		cfg_write(REG_DIM_MIN, 0);
		cfg_write(REG_TRACK_GATE, 0);
		send_cluster(500, 500, 1, 0, 1'b1);
		send_cluster(500, 500, 3, 50, 1'b1);
		drain();
	endtask

	task automatic test_random(int items);
		int sent, n, k;
		sent = 0;
		while (sent < items) begin
			k = $urandom_range(0, 4);
			for (int c = 0; c < k; c++) begin
				n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 12) : $urandom_range(3, 10);
				send_cluster($signed($urandom_range(0, 8000)) - 4000,
					$signed($urandom_range(0, 8000)) - 4000, n,
					$urandom_range(0, 300), 1'b0);
				sent += n;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_item($urandom_range(0, 1), $signed($urandom_range(0, 32767)) - 16384,
					$signed($urandom_range(0, 32767)) - 16384, $urandom_range(0, 1), 1'b0);
				sent++;
			end
			send_item($urandom_range(0, 1), $signed($urandom_range(0, 32767)) - 16384,
				$signed($urandom_range(0, 32767)) - 16384, 1'b0, 1'b1);
			sent++;
		end
		drain();
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++) send_cluster(200 * i, -150 * i, 5, 120, 1'b1);
		join
		drain();
	endtask

	initial begin
		cfg = '{min_points: 5, size_min: 82, size_max: 614, dim_min: 82, dim_max: 358,
			track_gate: 512, max_lost: 6};
		clear_cluster();
		bestx = 0; besty = 0; bestd = 32'h7FFFFFFF; ncand = 0;
		prevx = 0; prevy = 0; prevv = 1'b0; lost = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_lost_limit();
		test_big_cluster();
		cfg_write(REG_MIN_POINTS, 3);
		cfg_write(REG_SIZE_MIN, 40);
		cfg_write(REG_SIZE_MAX, 800);
		cfg_write(REG_DIM_MIN, 30);
		cfg_write(REG_DIM_MAX, 500);
		cfg_write(REG_TRACK_GATE, 3000);
		cfg_write(REG_MAX_LOST, 3);
		test_random(100);
		test_backpressure();
		stall_pct = 0; gap_pct = 0;
		cfg_write(REG_SIZE_MIN, 16383);
		cfg_write(REG_DIM_MIN, 16383);
		test_random(50);
		stall_pct = 50; gap_pct = 50;
		cfg_write(REG_SIZE_MIN, 82);
		cfg_write(REG_SIZE_MAX, 614);
		cfg_write(REG_DIM_MIN, 82);
		cfg_write(REG_DIM_MAX, 358);
		cfg_write(REG_TRACK_GATE, 512);
		cfg_write(REG_MIN_POINTS, 5);
		cfg_write(REG_MAX_LOST, 6);
		test_random(150);
		if (errors == 0)
			$display("lidar_cluster_target_selector verification clean");
		else
			$display("lidar_cluster_target_selector verification failed");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/lcts_pkg.sv
rtl/lcts_fifo.sv
rtl/lcts_front.sv
rtl/lcts_back.sv
rtl/lidar_cluster_target_selector.sv
verif/tb_top.sv
